FILE: design/assert_macros.svh
// assertion macros used by the top level rtl file
// expects signals clk and arst_n in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define VN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define VN_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/vn_pkg.sv
// shared constants, stage types and step functions of the vector normalizer
// no dependencies
`default_nettype none

package vn_pkg;

	localparam int COMP_W      = 32;
	localparam int SQ_W        = 64;
	localparam int QUO_W       = 66;
	localparam int DIV_STAGES  = QUO_W;
	localparam int SQRT_STAGES = QUO_W / 2;
	localparam int ROOT_W      = QUO_W / 2;
	localparam int SREM_W      = ROOT_W + 2;
	localparam int LATENCY     = DIV_STAGES + SQRT_STAGES + 2;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic              sign;
		logic [SQ_W-1:0]   c2;
	} lane_in_t;

	typedef struct packed {
		lane_in_t [3:0]    lane;
		logic [SQ_W-1:0]   s;
		logic              zero;
	} work_t;

	typedef struct packed {
		logic              valid;
		logic              full;
	} q_stat_t;

	typedef struct packed {
		logic              ov;
		logic              sign;
		logic [SQ_W-1:0]   s;
		logic [SQ_W-1:0]   rem;
		logic [COMP_W-1:0] nbits;
		logic [QUO_W-1:0]  quo;
	} div_t;

	typedef struct packed {
		logic              ov;
		logic              sign;
		logic [QUO_W-1:0]  rad;
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	function automatic logic [COMP_W-1:0] mag32(logic [COMP_W-1:0] v);
		return v[COMP_W-1] ? (~v + 1'b1) : v;
	endfunction

	// one restoring division step, one quotient bit
	function automatic div_t div_step(div_t a);
		logic [SQ_W:0] r2;
		div_t b;
		b = a;
		r2 = {a.rem, a.nbits[COMP_W-1]};
		b.nbits = {a.nbits[COMP_W-2:0], 1'b0};
		if (r2 >= {1'b0, a.s}) begin
			b.rem = SQ_W'(r2 - {1'b0, a.s});
			b.quo = {a.quo[QUO_W-2:0], 1'b1};
		end else begin
			b.rem = r2[SQ_W-1:0];
			b.quo = {a.quo[QUO_W-2:0], 1'b0};
		end
		return b;
	endfunction

	// one digit-by-digit square root step, one root bit
	function automatic sq_t sqrt_step(sq_t a);
		logic [SREM_W+1:0] r2;
		logic [SREM_W+1:0] trial;
		sq_t b;
		b = a;
		r2 = {a.rem, a.rad[QUO_W-1:QUO_W-2]};
		trial = {2'b00, a.root, 2'b01};
		b.rad = {a.rad[QUO_W-3:0], 2'b00};
		if (r2 >= trial) begin
			b.rem = SREM_W'(r2 - trial);
			b.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			b.rem = r2[SREM_W-1:0];
			b.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: design/vn_in_if.sv
// input channel of the vector normalizer: valid, ready and four components
// depends on vn_pkg
`default_nettype none

interface vn_in_if;
	logic                          valid;
	logic                          ready;
	logic signed [vn_pkg::COMP_W-1:0] in_x;
	logic signed [vn_pkg::COMP_W-1:0] in_y;
	logic signed [vn_pkg::COMP_W-1:0] in_z;
	logic signed [vn_pkg::COMP_W-1:0] in_w;

	modport source (output valid, in_x, in_y, in_z, in_w, input ready);
	modport sink (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

`default_nettype wire

FILE: design/vn_out_if.sv
// output channel of the vector normalizer: valid, ready, components and flags
// depends on vn_pkg
`default_nettype none

interface vn_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [vn_pkg::COMP_W-1:0] norm_x;
	logic signed [vn_pkg::COMP_W-1:0] norm_y;
	logic signed [vn_pkg::COMP_W-1:0] norm_z;
	logic signed [vn_pkg::COMP_W-1:0] norm_w;
	logic                          zero_length;
	logic                          saturated;

	modport source (output valid, norm_x, norm_y, norm_z, norm_w, zero_length, saturated,
		input ready);
	modport sink (input valid, norm_x, norm_y, norm_z, norm_w, zero_length, saturated,
		output ready);
endinterface

`default_nettype wire

FILE: design/vn_front.sv
// front end: accepts items, squares components, forms squared length
// depends on vn_pkg and vn_in_if
`default_nettype none

module vn_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	vn_in_if.sink               vec,
	input  wire vn_pkg::q_stat_t qst,
	output logic                push,
	output vn_pkg::work_t       push_data
);

	logic                   adv;
	logic                   vld_s1;
	logic                   vld_s2;
	logic [3:0]             sign_s1;
	logic [vn_pkg::SQ_W-1:0] sq_s1 [4];
	vn_pkg::work_t          work_s2;
	logic [vn_pkg::COMP_W-1:0] comp [4];
	logic [vn_pkg::SQ_W-1:0] sum;

	assign adv = !vld_s2 || !qst.full;
	assign vec.ready = adv;
	assign push = vld_s2 && adv;
	assign push_data = work_s2;

	assign comp[0] = vec.in_x;
	assign comp[1] = vec.in_y;
	assign comp[2] = vec.in_z;
	assign comp[3] = vec.in_w;
	assign sum = sq_s1[0] + sq_s1[1] + sq_s1[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vec.valid;
			vld_s2 <= vld_s1;
		end
	end

	// squares of magnitudes
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				sign_s1[i] <= comp[i][vn_pkg::COMP_W-1];
				sq_s1[i] <= vn_pkg::SQ_W'(vn_pkg::mag32(comp[i]))
					* vn_pkg::SQ_W'(vn_pkg::mag32(comp[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				work_s2.lane[i].sign <= sign_s1[i];
				work_s2.lane[i].c2 <= sq_s1[i];
			end
			work_s2.s <= sum;
			work_s2.zero <= (sum == '0);
		end
	end

endmodule

`default_nettype wire

FILE: design/vn_queue.sv
// short first-word-fall-through queue between front and back
// depends on vn_pkg
`default_nettype none

module vn_queue #(
	parameter int DEPTH = vn_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire vn_pkg::work_t  push_data,
	input  wire logic           pop,
	output vn_pkg::work_t       head,
	output vn_pkg::q_stat_t     qst
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	vn_pkg::work_t       mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_pop;

	assign qst.valid = (count_q != '0);
	assign qst.full = (count_q == CNT_W'(DEPTH));
	assign head = mem_q[rd_ptr_q];
	assign do_pop = pop && qst.valid;

	function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !do_pop) count_q <= CNT_W'(count_q + 1'b1);
			else if (!push && do_pop) count_q <= CNT_W'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

FILE: design/vn_lane.sv
// one component lane: quotient c2*2^34/s, its square root, rounding, clamping
// depends on vn_pkg
`default_nettype none

module vn_lane (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire vn_pkg::lane_in_t   li,
	input  wire logic [vn_pkg::SQ_W-1:0] s,
	output logic [vn_pkg::COMP_W-1:0] value,
	output logic                    sat
);

	localparam int W = vn_pkg::COMP_W;

	vn_pkg::div_t div_q [vn_pkg::DIV_STAGES+1];
	vn_pkg::sq_t  sq_q [vn_pkg::SQRT_STAGES];
	vn_pkg::sq_t  sq_init;
	logic         ov;
	logic [vn_pkg::ROOT_W:0] r;
	logic         sat_c;
	logic [W-1:0] val_c;
	vn_pkg::sq_t  last;

	// quotient would reach 2^66: far out of range
	assign ov = {{W{1'b0}}, li.c2[vn_pkg::SQ_W-1:W]} >= s;

	always_ff @(posedge clk) begin
		if (en) begin
			div_q[0].ov <= ov;
			div_q[0].sign <= li.sign;
			div_q[0].s <= s;
			div_q[0].rem <= ov ? '0 : {{W{1'b0}}, li.c2[vn_pkg::SQ_W-1:W]};
			div_q[0].nbits <= li.c2[W-1:0];
			div_q[0].quo <= '0;
		end
	end

	for (genvar k = 0; k < vn_pkg::DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) div_q[k+1] <= vn_pkg::div_step(div_q[k]);
		end
	end

	always_comb begin
		sq_init.ov = div_q[vn_pkg::DIV_STAGES].ov;
		sq_init.sign = div_q[vn_pkg::DIV_STAGES].sign;
		sq_init.rad = div_q[vn_pkg::DIV_STAGES].quo;
		sq_init.rem = '0;
		sq_init.root = '0;
	end

	always_ff @(posedge clk) begin
		if (en) sq_q[0] <= vn_pkg::sqrt_step(sq_init);
	end

	for (genvar k = 1; k < vn_pkg::SQRT_STAGES; k++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (en) sq_q[k] <= vn_pkg::sqrt_step(sq_q[k-1]);
		end
	end

	// odd root count gives round to nearest, ties away from zero
	assign last = sq_q[vn_pkg::SQRT_STAGES-1];
	assign r = {1'b0, last.root} + 1'b1;

	always_comb begin
		if (!last.sign) begin
			sat_c = last.ov || r[W+1] || r[W];
			val_c = sat_c ? {1'b0, {(W-1){1'b1}}} : r[W:1];
		end else begin
			sat_c = last.ov || r[W+1] || (r[W] && (r[W-1:1] != '0));
			val_c = sat_c ? {1'b1, {(W-1){1'b0}}} : (~r[W:1] + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value <= val_c;
			sat <= sat_c;
		end
	end

endmodule

`default_nettype wire

FILE: design/vn_back.sv
// back end: four lanes in lockstep, valid and zero tracking, output stage
// depends on vn_pkg, vn_lane and vn_out_if
`default_nettype none

module vn_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire vn_pkg::work_t  head,
	input  wire vn_pkg::q_stat_t qst,
	output logic                pop,
	vn_out_if.source            norm
);

	localparam int LAT = vn_pkg::LATENCY;

	logic                       en;
	logic [LAT-1:0]             vld_q;
	logic [LAT-1:0]             zero_q;
	logic [vn_pkg::COMP_W-1:0]  val [4];
	logic [3:0]                 sat;

	assign en = !vld_q[LAT-1] || norm.ready;
	assign pop = en && qst.valid;

	for (genvar i = 0; i < 4; i++) begin : g_lane
		vn_lane u_lane (
			.clk   (clk),
			.en    (en),
			.li    (head.lane[i]),
			.s     (head.s),
			.value (val[i]),
			.sat   (sat[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], qst.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) zero_q <= {zero_q[LAT-2:0], head.zero};
	end

	assign norm.valid = vld_q[LAT-1];
	assign norm.zero_length = zero_q[LAT-1];
	assign norm.saturated = !zero_q[LAT-1] && (sat != '0);
	assign norm.norm_x = zero_q[LAT-1] ? '0 : val[0];
	assign norm.norm_y = zero_q[LAT-1] ? '0 : val[1];
	assign norm.norm_z = zero_q[LAT-1] ? '0 : val[2];
	assign norm.norm_w = zero_q[LAT-1] ? '0 : val[3];

endmodule

`default_nettype wire

FILE: design/vector_normalize_unit.sv
// top level of the vector normalizer: front end, queue, back end
// depends on vn_pkg, vn_in_if, vn_out_if, vn_front, vn_queue, vn_back, assert_macros.svh
//
// usage
// - vec carries x, y, z, w in signed Q16.16; an item moves when valid and ready are high
// - norm returns x, y, z, w scaled by 1/sqrt(x*x+y*y+z*z), rounded to nearest,
//   ties away from zero; w is scaled but takes no part in the length
// - zero_length: x, y and z all zero; all four outputs are zero, saturated is low
// - saturated: a result left Q16.16 range and was clamped (only w can do that)
// - throughput: one item per cycle, sustained while norm.ready is high, with either side idling at will
// - path from acceptance to result valid: the front square and sum registers,
//   the queue write, the operand load, 66 division stages, 33 square root
//   stages and 1 rounding stage; the long restoring divide makes up most of
//   that path
// - a stalled receiver freezes the back pipeline; the queue keeps taking items
//   until full, then vec.ready drops
// - reset clears every valid bit and the queue; no item is held across reset
`default_nettype none
`include "assert_macros.svh"

module vector_normalize_unit #(
	parameter int QUEUE_DEPTH = vn_pkg::QUEUE_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	vn_in_if.sink       vec,
	vn_out_if.source    norm
);

	logic               push;
	logic               pop;
	vn_pkg::work_t      push_data;
	vn_pkg::work_t      head;
	vn_pkg::q_stat_t    qst;

	// squares and squared length
	vn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec       (vec),
		.qst       (qst),
		.push      (push),
		.push_data (push_data)
	);

	// decouples front stalls from back stalls
	vn_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qst       (qst)
	);

	// divide, root, round, clamp
	vn_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qst    (qst),
		.pop    (pop),
		.norm   (norm)
	);

	`VN_ASSERT(a_no_overflow, push |-> !qst.full, "push into full queue")
	`VN_ASSERT(a_zero_clean, norm.valid && norm.zero_length |-> !norm.saturated && norm.norm_x == 0 && norm.norm_w == 0,
		"zero length item with nonzero result")
	`VN_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !norm.valid && !qst.valid, "valid during reset")

endmodule

`default_nettype wire
